@@ hdl/ipv4_destination_blocklist_top_defines.svh @@
// assertion macros for the ipv4 destination blocklist checker
// used by ipv4dbl_checker; expects clk and rst_n in the calling scope
`ifndef IPV4_DESTINATION_BLOCKLIST_TOP_DEFINES_SVH
`define IPV4_DESTINATION_BLOCKLIST_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define IPV4DBL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("blocklist check failed");

// next-cycle implication, disabled during reset
`define IPV4DBL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("blocklist check failed");

`endif

@@ hdl/ipv4dbl_pkg.sv @@
// shared types and constants for the ipv4 destination blocklist
// no dependencies; imported by the cell, the top level and the checker
package ipv4dbl_pkg;

  localparam int ENTRIES_DEF = 64;
  localparam int ADDR_W      = 32;
  localparam int MODE_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 7;
  localparam int GRP_W       = 32;
  localparam int OUT_DATA_W  = 16;

  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic [ADDR_W-1:0] key;
    logic              add_go;
    logic              start_pull;
  } cell_ctl_t;

endpackage

@@ hdl/ipv4dbl_cell.sv @@
// one slot of the blocklist chain: stored address, match flag, pull token
// depends on ipv4dbl_pkg
module ipv4dbl_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ipv4dbl_pkg::cell_ctl_t         ctl,
  input  logic [CW-1:0]                  count,
  input  logic [ipv4dbl_pkg::ADDR_W-1:0] nbr_data,
  input  logic                           pull_in,
  output logic [ipv4dbl_pkg::ADDR_W-1:0] data,
  output logic                           pull_out,
  output logic                           match
);
  import ipv4dbl_pkg::*;

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic [ADDR_W-1:0] data_r;
  logic              pull_r;
  logic              match_r;

  // an add writes the key into the slot at the count; data moves down one slot while the removal token passes this cell
  always_ff @(posedge clk) begin
    if (ctl.add_go && (count == MY_IDX)) begin
      data_r <= ctl.key;
    end else if (pull_r) begin
      data_r <= nbr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pull_r  <= 1'b0;
      match_r <= 1'b0;
    end else begin
      pull_r  <= ctl.start_pull ? match_r : pull_in;
      match_r <= (count > MY_IDX) && (data_r == ctl.key);
    end
  end

  assign data     = data_r;
  assign pull_out = pull_r;
  assign match    = match_r;

endmodule

@@ hdl/ipv4_destination_blocklist_top.sv @@
// IPv4 destination blocklist: a chain of address cells and its controller
// depends on ipv4dbl_pkg and ipv4dbl_cell
//
// usage:
//   input channel in_*: one transfer per command; in_tuser holds the mode
//   (lookup, add, remove), in_tdata the address. result channel out_*: one
//   transfer per command with hit, status and the entry count after it.
//   every cell compares the address at once; the match flags are OR-ed in
//   a two-level tree whose first level is registered.
//   a command passes the compare, group, decide and output states; the
//   result is registered in the output state. a remove that hits then
//   enters a shift state while a token walks the chain one cell per
//   cycle, pulling every entry above the freed slot down by one.
//   in_tready is high only while the block waits for a command.
//   reset clears the entry count, the output valid flag and the controller;
//   the table contents are not cleared, slots at or above the count are
//   never compared.
//   when out_tready is low the finished result sits in the output register
//   and the controller waits for it to drain before loading the next one.
module ipv4_destination_blocklist_top #(
  parameter int ENTRIES = ipv4dbl_pkg::ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [31:0] address
  input  logic [ipv4dbl_pkg::ADDR_W-1:0]     in_tdata,
  // [1:0] mode
  input  logic [ipv4dbl_pkg::MODE_W-1:0]     in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] hit, [2:1] status, [9:3] entry_count, [15:10] zero
  output logic [ipv4dbl_pkg::OUT_DATA_W-1:0] out_tdata
);
  import ipv4dbl_pkg::*;

  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int NGRP = (ENTRIES + GRP_W - 1) / GRP_W;
  localparam int PADW = NGRP * GRP_W;
  localparam int PADZ = OUT_DATA_W - 1 - STATUS_W - COUNT_OUT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_GRP,
    S_DEC,
    S_OUT,
    S_SHIFT
  } state_t;

  state_t                  state_r;
  logic [ADDR_W-1:0]       key_r;
  logic [MODE_W-1:0]       mode_r;
  logic [CW-1:0]           count_r;
  logic [CW-1:0]           count_nxt;
  logic [CW-1:0]           shift_cnt_r;
  logic [NGRP-1:0]         grp_r;
  logic [NGRP-1:0]         grp_nxt;
  logic                    res_hit_r;
  logic                    res_hit_nxt;
  logic [STATUS_W-1:0]     res_status_r;
  logic [STATUS_W-1:0]     res_status_nxt;
  logic                    shift_pend_r;
  logic                    out_tvalid_r;
  logic [OUT_DATA_W-1:0]   out_tdata_r;
  logic                    load_out;
  logic                    add_go;
  logic                    start_pull;
  logic                    hit_any;
  cell_ctl_t               ctl;

  logic [ENTRIES-1:0]      match_v;
  logic [ENTRIES-1:0]      pull_v;
  logic [ADDR_W-1:0]       data_v [ENTRIES];
  logic [PADW-1:0]         match_pad;

  assign ctl.key        = key_r;
  assign ctl.add_go     = add_go;
  assign ctl.start_pull = start_pull;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [ADDR_W-1:0] nbr;
    logic              pin;
    if (i == ENTRIES - 1) begin : g_top
      assign nbr = data_v[i];
    end else begin : g_mid
      assign nbr = data_v[i+1];
    end
    if (i == 0) begin : g_first
      assign pin = 1'b0;
    end else begin : g_rest
      assign pin = pull_v[i-1];
    end
    ipv4dbl_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .count    (count_r),
      .nbr_data (nbr),
      .pull_in  (pin),
      .data     (data_v[i]),
      .pull_out (pull_v[i]),
      .match    (match_v[i])
    );
  end

  // first level of the match tree
  assign match_pad = PADW'(match_v);
  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    assign grp_nxt[g] = |match_pad[g*GRP_W +: GRP_W];
  end

  assign hit_any = |grp_r;

  // the output register takes a new result when it is empty or draining
  assign load_out = (state_r == S_OUT) && (!out_tvalid_r || out_tready);

  always_comb begin
    res_hit_nxt    = hit_any;
    res_status_nxt = STATUS_DONE;
    count_nxt      = count_r;
    add_go         = 1'b0;
    start_pull     = 1'b0;
    if ((state_r == S_DEC) && ((mode_r == MODE_ADD) || (mode_r == MODE_REMOVE))) begin
      if (key_r == '0) begin
        res_status_nxt = STATUS_ZERO;
        res_hit_nxt    = 1'b0;
      end else if (mode_r == MODE_ADD) begin
        if (!hit_any) begin
          if (count_r < CW'(ENTRIES)) begin
            add_go    = 1'b1;
            count_nxt = count_r + 1'b1;
          end else begin
            res_status_nxt = STATUS_FULL;
          end
        end
      end else if (hit_any) begin
        start_pull = 1'b1;
        count_nxt  = count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      shift_cnt_r  <= '0;
      shift_pend_r <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            key_r   <= in_tdata;
            mode_r  <= in_tuser;
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          state_r <= S_GRP;
        end
        S_GRP: begin
          grp_r   <= grp_nxt;
          state_r <= S_DEC;
        end
        S_DEC: begin
          count_r      <= count_nxt;
          res_hit_r    <= res_hit_nxt;
          res_status_r <= res_status_nxt;
          shift_pend_r <= start_pull;
          state_r      <= S_OUT;
        end
        S_OUT: begin
          if (load_out) begin
            out_tdata_r  <= {PADZ'(0), COUNT_OUT_W'(count_r), res_status_r, res_hit_r};
            if (shift_pend_r) begin
              shift_cnt_r <= CW'(ENTRIES);
              state_r     <= S_SHIFT;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_SHIFT: begin
          shift_cnt_r <= shift_cnt_r - 1'b1;
          if (shift_cnt_r == CW'(1)) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

@@ hdl/ipv4dbl_checker.sv @@
// port-level checks for the ipv4 destination blocklist, bound to the top level
// depends on ipv4dbl_pkg and ipv4_destination_blocklist_top_defines.svh
`include "ipv4_destination_blocklist_top_defines.svh"

module ipv4dbl_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic [ipv4dbl_pkg::ADDR_W-1:0]     in_tdata,
  input logic [ipv4dbl_pkg::MODE_W-1:0]     in_tuser,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [ipv4dbl_pkg::OUT_DATA_W-1:0] out_tdata
);
  import ipv4dbl_pkg::*;

  logic in_xfer;
  logic zero_cmd;

  assign in_xfer  = in_tvalid && in_tready;
  assign zero_cmd = (in_tdata == '0) && ((in_tuser == MODE_ADD) || (in_tuser == MODE_REMOVE));

  // a result is held until the receiver takes it
  `IPV4DBL_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  // one command at a time: busy right after a transfer
  `IPV4DBL_ASSERT_NEXT(a_busy_after_in, in_xfer, !in_tready)
  // a rejected zero address never reports a hit
  `IPV4DBL_ASSERT_IMP(a_zero_no_hit, out_tvalid && (out_tdata[2:1] == STATUS_ZERO), !out_tdata[0])
  // a full-table refusal only happens when the address was absent
  `IPV4DBL_ASSERT_IMP(a_full_no_hit, out_tvalid && (out_tdata[2:1] == STATUS_FULL), !out_tdata[0])
  // a zero add or remove leaves the block busy on the next cycle too
  `IPV4DBL_ASSERT_NEXT(a_zero_busy, in_xfer && zero_cmd, !in_tready)

endmodule

bind ipv4_destination_blocklist_top ipv4dbl_checker u_ipv4dbl_checker (.*);
